@@ rtl/core/lsp_pkg.sv @@
`timescale 1ns / 1ps
package lsp_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int SKIP_ROWS = 11;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ROW_W     = 19;
    localparam int CORDIC_N  = 16;
    localparam int STEP_W    = $clog2(CORDIC_N);
    localparam int CW        = 28;
    localparam int ZW        = 24;

    localparam logic signed [16:0] RIGHT_ANGLE_Q8 = 17'sd23040;
    localparam logic signed [16:0] STEER_MAX      = 17'sd65535;
    localparam logic signed [16:0] STEER_MIN      = 17'h10000;

    typedef enum logic [2:0] {
        REG_GAIN_PROP,
        REG_GAIN_INTEG,
        REG_GAIN_DERIV,
        REG_LANE_WIDTH,
        REG_CAR_X,
        REG_CAR_Y,
        REG_UNUSED6,
        REG_UNUSED7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_LEFT   = 2'd0,
        MODE_RIGHT  = 2'd1,
        MODE_NORMAL = 2'd2,
        MODE_BAD    = 2'd3
    } turn_mode_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_TARGET,
        ST_CORDIC,
        ST_ROUND,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_frame;
        logic target;
        logic cordic_init;
        logic cordic_step;
        logic round;
        logic mul;
        logic sum;
        logic commit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic usable;
        logic straight;
        logic level;
    } dp_stat_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            4'd0:    v = 24'd2949120;
            4'd1:    v = 24'd1740967;
            4'd2:    v = 24'd919879;
            4'd3:    v = 24'd466945;
            4'd4:    v = 24'd234379;
            4'd5:    v = 24'd117304;
            4'd6:    v = 24'd58666;
            4'd7:    v = 24'd29335;
            4'd8:    v = 24'd14668;
            4'd9:    v = 24'd7334;
            4'd10:   v = 24'd3667;
            4'd11:   v = 24'd1833;
            4'd12:   v = 24'd917;
            4'd13:   v = 24'd458;
            4'd14:   v = 24'd229;
            default: v = 24'd115;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/lsp_if.sv @@
`timescale 1ns / 1ps
interface lsp_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] left_x;
    logic [8:0] left_y;
    logic       left_present;
    logic [8:0] right_x;
    logic [8:0] right_y;
    logic       right_present;
    logic [1:0] turn_mode;
    logic [15:0] speed_in;
    logic       last_row;
    modport source (output valid, left_x, left_y, left_present, right_x, right_y,
                    right_present, turn_mode, speed_in, last_row, input ready);
    modport sink (input valid, left_x, left_y, left_present, right_x, right_y,
                  right_present, turn_mode, speed_in, last_row, output ready);
endinterface

interface lsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] steer_angle;
    logic [15:0]        speed_out;
    logic               bad_mode;
    modport source (output valid, steer_angle, speed_out, bad_mode, input ready);
    modport sink (input valid, steer_angle, speed_out, bad_mode, output ready);
endinterface

@@ rtl/core/lsp_ram.sv @@
`timescale 1ns / 1ps
module lsp_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lsp_datapath.sv @@
`timescale 1ns / 1ps
module lsp_datapath
    import lsp_pkg::*;
(
    input  logic               clk,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [1:0]         mode,
    input  logic [ROW_W-1:0]   left_row,
    input  logic [ROW_W-1:0]   right_row,
    input  logic [STEP_W-1:0]  step,
    input  logic [15:0]        gain_prop,
    input  logic [15:0]        gain_integ,
    input  logic [15:0]        gain_deriv,
    input  logic [8:0]         lane_width,
    input  logic [8:0]         car_x,
    input  logic [8:0]         car_y,
    input  logic signed [16:0] prev_error,
    output logic signed [16:0] error,
    output logic signed [16:0] steer
);

    logic signed [10:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW:0] cz_reg;
    logic signed [16:0] e_reg;
    logic signed [34:0] p0_reg, p1_reg, p2_reg;
    logic signed [16:0] steer_reg;

    logic lp, rp;
    logic row_usable;
    logic [8:0] lx, ly, rx, ry, half;
    logic [9:0] tx, ty;
    logic [9:0] ax, ay;
    logic signed [CW-1:0] xs, ys;
    logic [ZW:0] zr;
    logic signed [16:0] emag;
    logic signed [17:0] esum, edif;
    logic signed [37:0] total;
    logic signed [37:0] shifted;

    assign lp = left_row[18];
    assign rp = right_row[18];
    assign lx = left_row[8:0];
    assign ly = left_row[17:9];
    assign rx = right_row[8:0];
    assign ry = right_row[17:9];
    assign half = {1'b0, lane_width[8:1]};

    // row usable for the current mode
    always_comb
    begin
        unique case (mode)
            MODE_LEFT:   row_usable = lp;
            MODE_RIGHT:  row_usable = rp;
            MODE_NORMAL: row_usable = lp | rp;
            default:     row_usable = 1'b0;
        endcase
    end

    // target point and offset from car
    always_comb
    begin
        if (mode == MODE_NORMAL && lp && rp)
        begin
            tx = 10'(({1'b0, lx} + {1'b0, rx}) >> 1);
            ty = 10'(({1'b0, ly} + {1'b0, ry}) >> 1);
        end
        else if (mode == MODE_LEFT || (mode == MODE_NORMAL && lp))
        begin
            tx = {1'b0, lx} + {1'b0, half};
            ty = {1'b0, ly};
        end
        else
        begin
            tx = {1'b0, rx} - {1'b0, half};
            ty = {1'b0, ry};
        end
        // right lane minus half may wrap below zero: keep sign via 11 bits
        dx_next = (mode == MODE_NORMAL && lp && rp) || mode == MODE_LEFT
                  || (mode == MODE_NORMAL && lp)
                  ? $signed({1'b0, tx}) - $signed({2'b0, car_x})
                  : $signed({2'b0, rx}) - $signed({2'b0, half}) - $signed({2'b0, car_x});
        dy_next = $signed({2'b0, car_y}) - $signed({1'b0, ty});
    end

    assign stat = '{usable: row_usable, straight: (dx_reg == 11'sd0),
                    level: (dy_reg == 11'sd0)};
    assign ax = dx_reg[10] ? 10'(-dx_reg) : dx_reg[9:0];
    assign ay = dy_reg[10] ? 10'(-dy_reg) : dy_reg[9:0];
    assign xs = cx_reg >>> step;
    assign ys = cy_reg >>> step;

    // rounding of the cordic angle
    always_comb
    begin
        zr = cz_reg[ZW] ? '0 : ZW'(cz_reg[ZW-1:0] + 24'd128) >> 8;
        if (zr > 25'(RIGHT_ANGLE_Q8))
        begin
            emag = RIGHT_ANGLE_Q8;
        end
        else
        begin
            emag = 17'(zr);
        end
    end

    assign esum = 18'(e_reg) + 18'(prev_error);
    assign edif = 18'(e_reg) - 18'(prev_error);
    assign total = 38'(p0_reg) + 38'(p1_reg) + 38'(p2_reg) + 38'sd2048;
    assign shifted = total >>> 12;

    always_ff @(posedge clk)
    begin
        if (cmd.target)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.cordic_init)
        begin
            cx_reg <= CW'({ay, 16'd0});
            cy_reg <= CW'({ax, 16'd0});
            cz_reg <= '0;
        end
        else if (cmd.cordic_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed({1'b0, atan_entry(step)});
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed({1'b0, atan_entry(step)});
            end
        end
        if (cmd.round)
        begin
            e_reg <= (dx_reg[10] != dy_reg[10]) ? -emag : emag;
        end
        if (cmd.mul)
        begin
            p0_reg <= $signed({1'b0, gain_prop}) * e_reg;
            p1_reg <= 35'($signed({1'b0, gain_integ}) * esum);
            p2_reg <= 35'($signed({1'b0, gain_deriv}) * edif);
        end
        if (cmd.sum)
        begin
            if (shifted > 38'(STEER_MAX))
            begin
                steer_reg <= STEER_MAX;
            end
            else if (shifted < 38'(STEER_MIN))
            begin
                steer_reg <= STEER_MIN;
            end
            else
            begin
                steer_reg <= 17'(shifted);
            end
        end
        else if (cmd.load_frame)
        begin
            if (stat.straight)
            begin
                steer_reg <= '0;
            end
            else
            begin
                steer_reg <= dx_reg[10] ? -RIGHT_ANGLE_Q8 : RIGHT_ANGLE_Q8;
            end
        end
    end

    assign error = e_reg;
    assign steer = steer_reg;

endmodule

@@ rtl/core/lsp_ctrl.sv @@
`timescale 1ns / 1ps
module lsp_ctrl
    import lsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic [1:0]        in_mode,
    input  logic              out_free,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd,
    output logic              busy,
    output logic              emit,
    output logic              emit_bad,
    output logic [1:0]        mode,
    output logic [CNT_W-1:0]  row_count,
    output logic [ADDR_W-1:0] scan_addr,
    output logic [STEP_W-1:0] step
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [CNT_W:0] idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0] mode_reg, mode_next;
    logic [CNT_W-1:0] size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            mode_reg  <= MODE_NORMAL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
        end
    end

    assign size = (cnt_reg < CNT_W'(MAX_ROWS)) ? cnt_reg + 1'b1 : cnt_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        emit       = 1'b0;
        emit_bad   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (cnt_reg < CNT_W'(MAX_ROWS))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (in_last)
                    begin
                        cnt_next  = '0;
                        mode_next = in_mode;
                        idx_next  = $signed({1'b0, size}) - (CNT_W+1)'(SKIP_ROWS);
                        if (in_mode == MODE_BAD)
                        begin
                            emit     = 1'b1;
                            emit_bad = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (idx_reg < 0)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (stat.usable)
                begin
                    cmd.target = 1'b1;
                    state_next = ST_TARGET;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_TARGET:
            begin
                if (stat.straight || stat.level)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    cmd.cordic_init = 1'b1;
                    step_next       = '0;
                    state_next      = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_N - 1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum        = 1'b1;
                cmd.commit_err = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign busy      = (state_reg != ST_LOAD);
    assign mode      = mode_reg;
    assign row_count = cnt_reg;
    assign scan_addr = idx_reg[ADDR_W-1:0];
    assign step      = step_reg;

endmodule

@@ rtl/core/lane_steering_pid.sv @@
`timescale 1ns / 1ps
// lane steering controller with pid output
// in: one word per image row (left and right lane points); last_row closes
// the frame and carries turn_mode and speed_in
// out: at most one word per frame: steer_angle (q8.8 degrees, saturated),
// speed_out and bad_mode
// cfg: plain write port, registers indexed 0..5, take effect at once
// row words load back to back unless held off; rows past 256 are dropped
// on the last row the scan reads and then checks one stored row at a time,
// walking upward from eleven rows above the end; the bearing then takes 16 cordic
// iterations on a shared shift-add unit, followed by rounding, multiply and
// sum and then a load of the result register
// straight ahead or level targets skip the bearing and the pid sum
// an invalid mode answers in the cycle after the last row, with no scan
// input is held off while a frame is being closed; a stalled receiver holds
// the result register and in turn holds the input off
// reset clears the row count, the previous error and restores the register
// defaults; row memories are not cleared
module lane_steering_pid
    import lsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lsp_in_if.sink      in_ch,
    lsp_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [15:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [8:0] lane_width_reg, car_x_reg, car_y_reg;
    logic signed [16:0] prev_err_reg;
    logic out_valid_reg;
    logic signed [16:0] out_steer_reg;
    logic [15:0] out_speed_reg, speed_hold_reg;
    logic out_bad_reg;

    dp_cmd_t cmd;
    dp_stat_t stat;
    logic busy, emit, emit_bad, in_fire, out_free;
    logic [1:0] mode;
    logic [CNT_W-1:0] row_count;
    logic [ADDR_W-1:0] scan_addr;
    logic [STEP_W-1:0] step;
    logic [ROW_W-1:0] left_rd, right_rd;
    logic signed [16:0] error, steer;
    logic wr_en;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !busy && out_free;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign wr_en = in_fire && (row_count < CNT_W'(MAX_ROWS));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= 16'd4096;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            lane_width_reg <= 9'd80;
            car_x_reg      <= 9'd120;
            car_y_reg      <= 9'd300;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_wdata;
                REG_GAIN_INTEG: gain_integ_reg <= cfg_wdata;
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_wdata;
                REG_LANE_WIDTH: lane_width_reg <= cfg_wdata[8:0];
                REG_CAR_X:      car_x_reg      <= cfg_wdata[8:0];
                REG_CAR_Y:      car_y_reg      <= cfg_wdata[8:0];
                default:        ;
            endcase
        end
    end

    lsp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_left_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_count[ADDR_W-1:0]),
        .wdata ({in_ch.left_present, in_ch.left_y, in_ch.left_x}),
        .raddr (scan_addr),
        .rdata (left_rd)
    );

    lsp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_right_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_count[ADDR_W-1:0]),
        .wdata ({in_ch.right_present, in_ch.right_y, in_ch.right_x}),
        .raddr (scan_addr),
        .rdata (right_rd)
    );

    lsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (in_ch.last_row),
        .in_mode   (in_ch.turn_mode),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .emit      (emit),
        .emit_bad  (emit_bad),
        .mode      (mode),
        .row_count (row_count),
        .scan_addr (scan_addr),
        .step      (step)
    );

    lsp_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .left_row   (left_rd),
        .right_row  (right_rd),
        .step       (step),
        .gain_prop  (gain_prop_reg),
        .gain_integ (gain_integ_reg),
        .gain_deriv (gain_deriv_reg),
        .lane_width (lane_width_reg),
        .car_x      (car_x_reg),
        .car_y      (car_y_reg),
        .prev_error (prev_err_reg),
        .error      (error),
        .steer      (steer)
    );

    // previous error and result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit_err)
            begin
                prev_err_reg <= error;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.last_row)
        begin
            speed_hold_reg <= in_ch.speed_in;
        end
        if (emit)
        begin
            out_steer_reg <= emit_bad ? 17'sd0 : steer;
            out_speed_reg <= emit_bad ? in_ch.speed_in : speed_hold_reg;
            out_bad_reg   <= emit_bad;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.steer_angle = out_steer_reg;
    assign out_ch.speed_out   = out_speed_reg;
    assign out_ch.bad_mode    = out_bad_reg;

    // no new row taken while a frame is being closed
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ch.ready)
        else $error("row accepted while busy");

    // a waiting result is not overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !emit)
        else $error("result overwritten");

    // bad mode result carries zero angle
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.bad_mode |-> out_ch.steer_angle == 17'sd0)
        else $error("bad mode with nonzero angle");

endmodule

@@ bench/lsp_checker.sv @@
`timescale 1ns / 1ps
module lsp_checker
    import lsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lsp_in_if           in_ch,
    lsp_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          steer_pending,
    output int          steer_seen,
    output int          bad_seen
);

    typedef struct packed {
        logic signed [16:0] angle;
        logic [15:0]        speed;
        logic               bad;
    } steer_word_t;

    // stored lane points of the open frame
    logic [8:0] lx_mem [MAX_ROWS];
    logic [8:0] ly_mem [MAX_ROWS];
    logic       lp_mem [MAX_ROWS];
    logic [8:0] rx_mem [MAX_ROWS];
    logic [8:0] ry_mem [MAX_ROWS];
    logic       rp_mem [MAX_ROWS];
    int         rows_held;
    logic signed [16:0] last_bearing;

    logic [15:0] kp, ki, kd;
    logic [8:0]  lane_w, cx, cy;

    steer_word_t steer_q[$];

    localparam longint ATAN_Q16 [16] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    // cordic vectoring, magnitude in q8.8 degrees
    function automatic longint bearing_q8(input longint ax, input longint ay);
        longint x, y, z, xs, ys;
        x = ay * 65536;
        y = ax * 65536;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end
        end
        if (z < 0)
            z = 0;
        z = (z + 128) >>> 8;
        if (z > 23040)
            z = 23040;
        return z;
    endfunction

    // bearing to target and pid sum; updates the error history unless straight or level
    function automatic longint steer_for(input longint tx, input longint ty);
        longint dx, dy, e, sum, res;
        dx = tx - longint'(cx);
        dy = longint'(cy) - ty;
        if (dx == 0)
            return 0;
        if (dy == 0)
            return (dx < 0) ? -23040 : 23040;
        e = bearing_q8(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if ((dx < 0) != (dy < 0))
            e = -e;
        sum = longint'(kp) * e + longint'(ki) * (e + last_bearing)
            + longint'(kd) * (e - last_bearing);
        res = (sum + 2048) >>> 12;
        if (res < -65536)
            res = -65536;
        if (res > 65535)
            res = 65535;
        last_bearing = 17'(e);
        return res;
    endfunction

    // close the frame and queue its steering word, if any
    task automatic close_frame(input turn_mode_t mode, input logic [15:0] spd);
        steer_word_t w;
        longint tx, ty, half;
        int n;
        n = rows_held;
        rows_held = 0;
        w.speed = spd;
        if (mode == MODE_BAD)
        begin
            w.angle = '0;
            w.bad = 1'b1;
            steer_q.push_back(w);
            return;
        end
        half = longint'(lane_w >> 1);
        for (int i = n - SKIP_ROWS; i >= 0; i--)
        begin
            if (mode == MODE_LEFT && !lp_mem[i])
                continue;
            if (mode == MODE_RIGHT && !rp_mem[i])
                continue;
            if (mode == MODE_NORMAL && !lp_mem[i] && !rp_mem[i])
                continue;
            if (mode == MODE_NORMAL && lp_mem[i] && rp_mem[i])
            begin
                tx = (longint'(lx_mem[i]) + longint'(rx_mem[i])) / 2;
                ty = (longint'(ly_mem[i]) + longint'(ry_mem[i])) / 2;
            end
            else if (mode == MODE_LEFT || (mode == MODE_NORMAL && lp_mem[i]))
            begin
                tx = longint'(lx_mem[i]) + half;
                ty = longint'(ly_mem[i]);
            end
            else
            begin
                tx = longint'(rx_mem[i]) - half;
                ty = longint'(ry_mem[i]);
            end
            w.angle = 17'(steer_for(tx, ty));
            w.bad = 1'b0;
            steer_q.push_back(w);
            return;
        end
    endtask

    assign steer_pending = steer_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_held = 0;
            last_bearing = '0;
            kp = 16'd4096;
            ki = '0;
            kd = '0;
            lane_w = 9'd80;
            cx = 9'd120;
            cy = 9'd300;
            steer_q.delete();
            fail_count = 0;
            steer_seen = 0;
            bad_seen = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_GAIN_PROP:  kp = cfg_wdata;
                    REG_GAIN_INTEG: ki = cfg_wdata;
                    REG_GAIN_DERIV: kd = cfg_wdata;
                    REG_LANE_WIDTH: lane_w = cfg_wdata[8:0];
                    REG_CAR_X:      cx = cfg_wdata[8:0];
                    REG_CAR_Y:      cy = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // result word against the oldest expectation
            if (out_ch.valid && out_ch.ready)
            begin
                steer_seen++;
                if (out_ch.bad_mode)
                    bad_seen++;
                if (steer_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word angle=%0d speed=%0d bad=%0b", $time,
                             out_ch.steer_angle, out_ch.speed_out, out_ch.bad_mode);
                end
                else
                begin
                    steer_word_t w;
                    w = steer_q.pop_front();
                    if (out_ch.steer_angle !== w.angle)
                    begin
                        fail_count++;
                        $display("%0t: steer_angle expected %0d actual %0d", $time,
                                 w.angle, out_ch.steer_angle);
                    end
                    if (out_ch.speed_out !== w.speed)
                    begin
                        fail_count++;
                        $display("%0t: speed_out expected %0d actual %0d", $time,
                                 w.speed, out_ch.speed_out);
                    end
                    if (out_ch.bad_mode !== w.bad)
                    begin
                        fail_count++;
                        $display("%0t: bad_mode expected %0b actual %0b", $time,
                                 w.bad, out_ch.bad_mode);
                    end
                end
            end
            // row word: store, and close on last row
            if (in_ch.valid && in_ch.ready)
            begin
                if (rows_held < MAX_ROWS)
                begin
                    lx_mem[rows_held] = in_ch.left_x;
                    ly_mem[rows_held] = in_ch.left_y;
                    lp_mem[rows_held] = in_ch.left_present;
                    rx_mem[rows_held] = in_ch.right_x;
                    ry_mem[rows_held] = in_ch.right_y;
                    rp_mem[rows_held] = in_ch.right_present;
                    rows_held++;
                end
                if (in_ch.last_row)
                    close_frame(turn_mode_t'(in_ch.turn_mode), in_ch.speed_in);
            end
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import lsp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 700;
    localparam int TOTAL_ROWS = 1150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count, steer_pending, steer_seen, bad_seen;
    int          rows_sent, frames_sent, idle_cycles;
    bit          no_gaps;
    int          stall_left;
    logic [8:0]  car_x_now, car_y_now;

    lsp_in_if  in_ch ();
    lsp_out_if out_ch ();

    lane_steering_pid DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lsp_checker steer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .steer_pending (steer_pending),
        .steer_seen    (steer_seen),
        .bad_seen      (bad_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [8:0] coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 9'd0;
        if (r == 1)
            return 9'd511;
        return 9'($urandom_range(0, 511));
    endfunction

    // receiver back-pressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left <= gap_len();
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one row word; called at a falling edge, returns at a falling edge
    task automatic send_row(input logic [8:0] lx, ly, input logic lp,
                            input logic [8:0] rx, ry, input logic rp,
                            input turn_mode_t mode, input logic [15:0] spd,
                            input logic last);
        int g;
        in_ch.valid = 1'b1;
        in_ch.left_x = lx;
        in_ch.left_y = ly;
        in_ch.left_present = lp;
        in_ch.right_x = rx;
        in_ch.right_y = ry;
        in_ch.right_present = rp;
        in_ch.turn_mode = mode;
        in_ch.speed_in = spd;
        in_ch.last_row = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        rows_sent++;
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // a frame of n rows; special row planted where the scan starts (n up to 256)
    task automatic send_frame(input int n, input turn_mode_t mode, input int plant,
                              input int present_pct);
        logic [8:0] lx, ly, rx, ry;
        logic lp, rp;
        for (int i = 0; i < n; i++)
        begin
            lx = coord();
            ly = coord();
            rx = coord();
            ry = coord();
            lp = ($urandom_range(0, 99) < present_pct);
            rp = ($urandom_range(0, 99) < present_pct);
            if (i == n - SKIP_ROWS && plant != 0)
            begin
                lp = 1'b1;
                rp = 1'b1;
                if (plant == 1)
                begin
                    // straight ahead in normal mode
                    lx = car_x_now;
                    rx = car_x_now;
                end
                else
                begin
                    // level with the car
                    ly = car_y_now;
                    ry = car_y_now;
                end
            end
            send_row(lx, ly, lp, rx, ry, rp,
                     (i == n - 1) ? mode : turn_mode_t'(2'($urandom)),
                     16'($urandom), i == n - 1);
        end
        frames_sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // settle, then load all six registers
    task automatic load_setting(input logic [15:0] p, i, d, input logic [8:0] w, x, y);
        in_ch.valid = 1'b0;
        wait (steer_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(REG_GAIN_PROP, p);
        write_reg(REG_GAIN_INTEG, i);
        write_reg(REG_GAIN_DERIV, d);
        write_reg(REG_LANE_WIDTH, 16'(w));
        write_reg(REG_CAR_X, 16'(x));
        write_reg(REG_CAR_Y, 16'(y));
        car_x_now = x;
        car_y_now = y;
    endtask

    initial
    begin
        int r, n, plant, pct;
        turn_mode_t mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.left_x = '0;
        in_ch.left_y = '0;
        in_ch.left_present = 1'b0;
        in_ch.right_x = '0;
        in_ch.right_y = '0;
        in_ch.right_present = 1'b0;
        in_ch.turn_mode = MODE_LEFT;
        in_ch.speed_in = '0;
        in_ch.last_row = 1'b0;
        rows_sent = 0;
        frames_sent = 0;
        no_gaps = 1'b0;
        car_x_now = 9'd120;
        car_y_now = 9'd300;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: invalid mode, too short, a left lane point only on the last row, past the scan start
        send_row(9'd511, 9'd511, 1'b1, 9'd511, 9'd511, 1'b1, MODE_BAD, 16'hFFFF, 1'b1);
        send_frame(3, MODE_NORMAL, 0, 100);
        for (int i = 0; i < 10; i++)
            send_row(9'd0, 9'd0, 1'b0, 9'd0, 9'd0, 1'b0, MODE_LEFT, 16'd0, 1'b0);
        send_row(9'd80, 9'd0, 1'b1, 9'd0, 9'd0, 1'b0, MODE_LEFT, 16'd0, 1'b1);

        // random frames over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1: load_setting(16'($urandom), 16'($urandom_range(0, 8191)),
                                16'($urandom_range(0, 8191)), coord(), coord(), coord());
                2: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511, 9'd511, 9'd511);
                3: load_setting(16'd0, 16'd0, 16'd0, 9'd0, 9'd0, 9'd0);
                4: load_setting(16'd2048, 16'd1024, 16'd4096, 9'd100, 9'd256, 9'd480);
                5: load_setting(16'($urandom), 16'($urandom), 16'($urandom),
                                9'($urandom), 9'($urandom), 9'($urandom));
                default: ;
            endcase
            no_gaps = (ph == 4);
            while (rows_sent < (ph + 1) * TOTAL_ROWS / 6)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    n = $urandom_range(256, 270);
                else if (r < 17)
                    n = $urandom_range(1, 10);
                else
                    n = $urandom_range(11, 30);
                r = $urandom_range(0, 99);
                mode = (r < 6) ? MODE_BAD : turn_mode_t'($urandom_range(0, 2));
                r = $urandom_range(0, 9);
                plant = (r == 0) ? 1 : (r == 1) ? 2 : 0;
                pct = ($urandom_range(0, 4) == 0) ? 10 : 75;
                send_frame(n, mode, plant, pct);
                // in phase 1, every tenth frame, the sender holds until the block has answered everything
                if (ph == 1 && frames_sent % 10 == 0)
                begin
                    in_ch.valid = 1'b0;
                    wait (steer_pending == 0);
                    @(negedge clk);
                end
            end
        end

        in_ch.valid = 1'b0;
        wait (steer_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("rows %0d in %0d frames, %0d steering words (%0d bad mode), 6 settings",
                 rows_sent, frames_sent, steer_seen, bad_seen);
        if (fail_count == 0 && steer_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
